// ===== hw/rtl/swc_pkg.sv =====
// Shared types and constants of the sliding window convolution block.
package swc_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxRadius = 2;
  localparam int KSide     = 2 * MaxRadius + 1;
  localparam int KSize     = KSide * KSide;
  localparam int ColBits   = 10;
  localparam int RowBits   = 12;
  localparam int SumBits   = 29;
  localparam int ProdBits  = 24;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  typedef struct packed {
    logic               operation;
    logic [4:0]         coef_index;
    logic signed [15:0] coef_value;
    logic [7:0]         pixel_value;
    logic               frame_start;
  } in_item_t;

  typedef struct packed {
    logic signed [28:0] filtered_value;
    logic [11:0]        center_row;
    logic [9:0]         center_col;
    logic               last_of_frame;
  } out_item_t;

  // Tag of a pixel that travels beside the line store read.
  typedef struct packed {
    logic         emit;
    logic [2:0]   slot;
    logic [11:0]  crow;
    logic [9:0]   ccol;
    logic         last;
    logic [1:0]   radius;
    logic [7:0]   pixel;
  } tap_tag_t;

endpackage

// ===== hw/rtl/swc_ram.sv =====
// Generic single-port-write, one-read synchronous RAM with registered read.
module swc_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/swc_mac.sv =====
// Window multiply and a registered adder tree in three stages: products, row sums, total.
module swc_mac (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  in_vld,
  input  logic [7:0]            win [swc_pkg::KSize],
  input  logic signed [15:0]    coef [swc_pkg::KSize],
  input  logic [1:0]            radius,
  input  logic [11:0]           crow,
  input  logic [9:0]            ccol,
  input  logic                  last,
  output logic                  out_vld,
  output swc_pkg::out_item_t    result
);

  localparam int KS = swc_pkg::KSide;
  localparam int KN = swc_pkg::KSize;

  logic signed [swc_pkg::ProdBits-1:0] prod_r [KN];
  logic signed [swc_pkg::SumBits-1:0]  row_sum_r [KS];
  logic [2:0]  vld_r;
  logic [11:0] crow_r [3];
  logic [9:0]  ccol_r [3];
  logic [2:0]  last_r;
  logic signed [swc_pkg::SumBits-1:0]  total_r;

  // The window is right aligned at the newest column and bottom row.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < KS; a++) begin
        for (int b = 0; b < KS; b++) begin
          logic [2:0] k;
          logic [2:0] wa;
          logic [2:0] wb;
          k  = {radius, 1'b0} + 3'd1;
          wa = 3'(a) + 3'(KS) - k;
          wb = 3'(b) + 3'(KS) - k;
          if (3'(a) < k && 3'(b) < k) begin
            prod_r[a*KS+b] <= $signed({1'b0, win[32'(wa)*KS + 32'(wb)]}) * coef[a*KS+b];
          end else begin
            prod_r[a*KS+b] <= '0;
          end
        end
      end
      for (int a = 0; a < KS; a++) begin
        logic signed [swc_pkg::SumBits-1:0] s;
        s = '0;
        for (int b = 0; b < KS; b++) begin
          s = s + swc_pkg::SumBits'(prod_r[a*KS+b]);
        end
        row_sum_r[a] <= s;
      end
      begin
        logic signed [swc_pkg::SumBits-1:0] t;
        t = '0;
        for (int a = 0; a < KS; a++) begin
          t = t + row_sum_r[a];
        end
        total_r <= t;
      end
      crow_r[0] <= crow;
      ccol_r[0] <= ccol;
      crow_r[1] <= crow_r[0];
      ccol_r[1] <= ccol_r[0];
      crow_r[2] <= crow_r[1];
      ccol_r[2] <= ccol_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      last_r <= '0;
    end else if (adv) begin
      vld_r  <= {vld_r[1:0], in_vld};
      last_r <= {last_r[1:0], last};
    end
  end

  assign out_vld = vld_r[2];
  assign result  = '{filtered_value: total_r, center_row: crow_r[2],
                     center_col: ccol_r[2], last_of_frame: last_r[2]};

endmodule

// ===== hw/rtl/sliding_window_convolution.sv =====
// Top level of the sliding window convolution block.
// Takes one request a cycle: a pixel or a coefficient load. Pixels in raster
// order are written to a line store of five row slots by 1024 columns held in
// one RAM with a registered read; each pixel reads the word of its column,
// puts itself into the slot of its row, writes the word back and shifts that
// column into a 5x5 window register. Once the window lies inside the image it
// yields one result, registered through the store read, window register,
// multiply, row sums, total and output register. The pipeline halts only while
// the output register is full and stalled. Coefficients go to a 25-entry table
// cleared at reset; a load passes the load registers ld1 and ld2 before it
// reaches the table, so a load behind a pixel in flight affects only later pixels.
module sliding_window_convolution (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  swc_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output swc_pkg::out_item_t   out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [12:0]          cfg_data
);

  localparam int KS = swc_pkg::KSide;
  localparam int KN = swc_pkg::KSize;

  logic [10:0] width_r;
  logic [12:0] height_r;
  logic [1:0]  radius_r;
  logic [9:0]  col_r;
  logic [11:0] row_r;
  logic [2:0]  slot_r;
  logic signed [15:0] coef_r [KN];
  logic [7:0]  win_r [KN];

  logic               ld1_vld_r;
  logic [4:0]         ld1_idx_r;
  logic signed [15:0] ld1_val_r;
  logic               ld2_vld_r;
  logic [4:0]         ld2_idx_r;
  logic signed [15:0] ld2_val_r;

  logic adv;
  logic acc;
  logic pix;

  // Output register; the pipeline moves whenever it can accept.
  logic               ovld_r;
  swc_pkg::out_item_t odata_r;
  logic               mvld;
  swc_pkg::out_item_t mres;

  assign adv      = !ovld_r || !out_stall;
  assign in_stall = !adv;
  assign acc      = in_valid && adv;
  assign pix      = acc && (in_data.operation == swc_pkg::OP_PIXEL);

  // Effective configuration.
  logic [10:0] w_eff;
  logic [12:0] h_eff;
  logic [1:0]  r_eff;
  logic [2:0]  k_eff;
  assign w_eff = (width_r == '0) ? 11'd1 : ((width_r > 11'd1024) ? 11'd1024 : width_r);
  assign h_eff = (height_r == '0) ? 13'd1 : ((height_r > 13'd4096) ? 13'd4096 : height_r);
  assign r_eff = (radius_r > 2'(swc_pkg::MaxRadius)) ? 2'(swc_pkg::MaxRadius) : radius_r;
  assign k_eff = {r_eff, 1'b0} + 3'd1;

  logic [9:0]  col_cur;
  logic [11:0] row_cur;
  logic [2:0]  slot_cur;
  assign col_cur  = in_data.frame_start ? '0 : col_r;
  assign row_cur  = in_data.frame_start ? '0 : row_r;
  assign slot_cur = in_data.frame_start ? '0 : slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd640;
      height_r <= 13'd480;
      radius_r <= 2'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        swc_pkg::REG_WIDTH:  width_r  <= cfg_data[10:0];
        swc_pkg::REG_HEIGHT: height_r <= cfg_data;
        swc_pkg::REG_RADIUS: radius_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
    end else if (pix) begin
      if ({1'b0, col_cur} + 11'd1 >= w_eff) begin
        col_r <= '0;
        if ({1'b0, row_cur} + 13'd1 >= h_eff) begin
          row_r  <= '0;
          slot_r <= '0;
        end else begin
          row_r  <= row_cur + 12'd1;
          slot_r <= (slot_cur == 3'(KS - 1)) ? '0 : slot_cur + 3'd1;
        end
      end else begin
        col_r  <= col_cur + 10'd1;
        row_r  <= row_cur;
        slot_r <= slot_cur;
      end
    end
  end

  // A load travels two stages before it reaches the table, so pixels taken
  // earlier still multiply with the old coefficient.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld1_vld_r <= 1'b0;
      ld2_vld_r <= 1'b0;
    end else if (adv) begin
      ld1_vld_r <= acc && (in_data.operation == swc_pkg::OP_LOAD)
                       && (in_data.coef_index < 5'(KN));
      ld2_vld_r <= ld1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ld1_idx_r <= in_data.coef_index;
      ld1_val_r <= in_data.coef_value;
      ld2_idx_r <= ld1_idx_r;
      ld2_val_r <= ld1_val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KN; i++) coef_r[i] <= '0;
    end else if (adv && ld2_vld_r) begin
      coef_r[ld2_idx_r] <= ld2_val_r;
    end
  end

  // Line store: one word per column holds the five row slots. Each pixel
  // reads its column word, replaces the byte of its row slot and writes the
  // word back. A write to the same column on the edge of the read is
  // forwarded from the register of the last written word.
  localparam int LineBits = 8 * KS;
  logic [LineBits-1:0] rd_word;
  logic [LineBits-1:0] wr_word;
  swc_pkg::tap_tag_t tag_r;
  logic tvld_r;
  logic [9:0] tcol_r;
  logic fwd_vld_r;
  logic [9:0] fwd_col_r;
  logic [LineBits-1:0] fwd_word_r;
  logic fwd_hit;

  swc_ram #(.Width(LineBits), .Depth(swc_pkg::MaxWidth)) u_line (
    .clk     (clk),
    .wr_en   (tvld_r && adv),
    .wr_addr (tcol_r),
    .wr_data (wr_word),
    .rd_en   (adv),
    .rd_addr (col_cur),
    .rd_data (rd_word)
  );

  assign fwd_hit = fwd_vld_r && (fwd_col_r == tcol_r);

  always_comb begin
    wr_word = fwd_hit ? fwd_word_r : rd_word;
    wr_word[{tag_r.slot, 3'b000} +: 8] = tag_r.pixel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tvld_r    <= 1'b0;
      fwd_vld_r <= 1'b0;
    end else if (adv) begin
      tvld_r    <= pix;
      fwd_vld_r <= tvld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_col_r  <= tcol_r;
      fwd_word_r <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tcol_r       <= col_cur;
      tag_r.emit   <= pix && ({1'b0, row_cur} + 13'd1 >= 13'(k_eff))
                          && ({1'b0, col_cur} + 11'd1 >= 11'(k_eff));
      tag_r.slot   <= slot_cur;
      tag_r.crow   <= row_cur - 12'(r_eff);
      tag_r.ccol   <= col_cur - 10'(r_eff);
      tag_r.last   <= ({1'b0, row_cur} == h_eff - 13'd1) && ({1'b0, col_cur} == w_eff - 11'd1);
      tag_r.radius <= r_eff;
      tag_r.pixel  <= in_data.pixel_value;
    end
  end

  // Window register: columns shift left, new column enters at the right.
  // Window row a holds the slot of image row (row - 4 + a).
  always_ff @(posedge clk) begin
    if (adv && tvld_r) begin
      for (int a = 0; a < KS; a++) begin
        for (int b = 0; b < KS - 1; b++) begin
          win_r[a*KS+b] <= win_r[a*KS+b+1];
        end
      end
      for (int a = 0; a < KS; a++) begin
        int s;
        s = int'(tag_r.slot) + 1 + a;
        if (s >= KS) s = s - KS;
        win_r[a*KS+KS-1] <= wr_word[8*s +: 8];
      end
    end
  end

  logic emit_r;
  logic [11:0] crow_r;
  logic [9:0]  ccol_r;
  logic last_r;
  logic [1:0] rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r <= 1'b0;
    end else if (adv) begin
      emit_r <= tvld_r && tag_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      crow_r <= tag_r.crow;
      ccol_r <= tag_r.ccol;
      last_r <= tag_r.last;
      rad_r  <= tag_r.radius;
    end
  end

  swc_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (emit_r),
    .win     (win_r),
    .coef    (coef_r),
    .radius  (rad_r),
    .crow    (crow_r),
    .ccol    (ccol_r),
    .last    (last_r),
    .out_vld (mvld),
    .result  (mres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (adv) begin
      ovld_r <= mvld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) odata_r <= mres;
  end

  assign out_valid = ovld_r;
  assign out_data  = odata_r;

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ovld_r && out_stall)
    else $error("input stalled without a blocked result");
  a_no_emit_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_data.operation == swc_pkg::OP_LOAD |=> !tvld_r)
    else $error("load request entered the pixel path");

endmodule

// ===== verif/sliding_window_convolution_test.sv =====
// Self-checking testbench of the sliding window convolution block.
module sliding_window_convolution_test;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  swc_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  swc_pkg::out_item_t out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = swc_pkg::REG_WIDTH;
  logic [12:0] cfg_data = '0;

  sliding_window_convolution dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Requests still to be driven and results still to arrive.
  swc_pkg::in_item_t  pending_requests[$];
  swc_pkg::out_item_t expected_pixels[$];
  int        errors = 0;
  int        queued_count = 0;
  bit        calm = 1'b0;

  // Shadow of the block state.
  logic [7:0] row_store[swc_pkg::KSide][swc_pkg::MaxWidth];
  int         kernel_coef[swc_pkg::KSize];
  int         col_pos = 0;
  int         row_pos = 0;
  int         width_reg = 640;
  int         height_reg = 480;
  int         radius_reg = 1;

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic convolve_request(input swc_pkg::in_item_t it);
    int w, h, r, k;
    longint acc;
    swc_pkg::out_item_t res;
    if (it.operation == swc_pkg::OP_LOAD) begin
      if (it.coef_index < swc_pkg::KSize) kernel_coef[it.coef_index] = it.coef_value;
      return;
    end
    w = clamp(width_reg, 1, swc_pkg::MaxWidth);
    h = clamp(height_reg, 1, 4096);
    r = clamp(radius_reg, 0, swc_pkg::MaxRadius);
    k = 2 * r + 1;
    if (it.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    row_store[row_pos % swc_pkg::KSide][col_pos] = it.pixel_value;
    if (row_pos + 1 >= k && col_pos + 1 >= k) begin
      acc = 0;
      for (int a = 0; a < k; a++)
        for (int b = 0; b < k; b++)
          acc += longint'(row_store[(row_pos + 1 - k + a) % swc_pkg::KSide]
                                   [col_pos + 1 - k + b])
                 * longint'(kernel_coef[a * swc_pkg::KSide + b]);
      res.filtered_value = acc[28:0];
      res.center_row = 12'(row_pos - r);
      res.center_col = 10'(col_pos - r);
      res.last_of_frame = (row_pos == h - 1 && col_pos == w - 1);
      expected_pixels.push_back(res);
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  // Driver: inputs change at the falling edge.
  bit taken = 1'b0;
  int in_gap = 0;
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !taken)) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_requests.size() > 0) begin
        in_data <= pending_requests.pop_front();
        in_valid <= 1'b1;
        in_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
    taken = 1'b0;
  end

  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (!calm && $urandom_range(0, 99) < 25)
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                  : $urandom_range(1, 3);
    end
  end

  // Monitor: requests and results are sampled at the rising edge.
  always @(posedge clk) begin
    swc_pkg::out_item_t want;
    if (rst_n && in_valid && !in_stall) begin
      taken = 1'b1;
      convolve_request(in_data);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result %h", out_data);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_data.filtered_value !== want.filtered_value) begin
          $error("filtered_value expected %0d got %0d", want.filtered_value,
                 out_data.filtered_value);
          errors++;
        end
        if (out_data.center_row !== want.center_row) begin
          $error("center_row expected %0d got %0d", want.center_row, out_data.center_row);
          errors++;
        end
        if (out_data.center_col !== want.center_col) begin
          $error("center_col expected %0d got %0d", want.center_col, out_data.center_col);
          errors++;
        end
        if (out_data.last_of_frame !== want.last_of_frame) begin
          $error("last_of_frame expected %0b got %0b", want.last_of_frame,
                 out_data.last_of_frame);
          errors++;
        end
      end
    end
  end

  task automatic queue_load(input int idx, input int value);
    swc_pkg::in_item_t it;
    it = '0;
    it.operation = swc_pkg::OP_LOAD;
    it.coef_index = 5'(idx);
    it.coef_value = 16'(value);
    it.pixel_value = 8'($urandom);
    it.frame_start = 1'($urandom);
    pending_requests.push_back(it);
    queued_count++;
  endtask

  function automatic int random_coef();
    case ($urandom_range(0, 7))
      0: return -32768;
      1: return 32767;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  function automatic logic [7:0] random_pixel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // Queues up to count pixels of a frame; loads are mixed in at load_pct.
  task automatic queue_frame(input int w, input int h, input int count,
                             input bit mark, input int load_pct);
    swc_pkg::in_item_t it;
    for (int n = 0; n < count && n < w * h; n++) begin
      if ($urandom_range(0, 99) < load_pct)
        queue_load($urandom_range(0, 31), random_coef());
      it.operation = swc_pkg::OP_PIXEL;
      it.coef_index = 5'($urandom);
      it.coef_value = 16'($urandom);
      it.pixel_value = random_pixel();
      it.frame_start = (n == 0) && mark;
      pending_requests.push_back(it);
      queued_count++;
    end
  endtask

  // Waits until the block is drained, then writes all three registers.
  task automatic set_geometry(input int w, input int h, input int r);
    while (pending_requests.size() > 0 || in_valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= swc_pkg::REG_WIDTH;
    cfg_data <= 13'(w);
    @(negedge clk);
    cfg_index <= swc_pkg::REG_HEIGHT;
    cfg_data <= 13'(h);
    @(negedge clk);
    cfg_index <= swc_pkg::REG_RADIUS;
    cfg_data <= 13'(r);
    @(negedge clk);
    cfg_we <= 1'b0;
    width_reg = w & 11'h7ff;
    height_reg = h & 13'h1fff;
    radius_reg = r & 2'h3;
  endtask

  initial begin
    int w, h, roll;
    foreach (kernel_coef[i]) kernel_coef[i] = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: coefficient extremes, ignored indexes, tiny frames.
    queue_load(0, -32768);
    queue_load(24, 32767);
    queue_load(25, 12345);
    queue_load(31, -1);
    queue_load(12, 32767);
    set_geometry(3, 3, 1);
    queue_frame(3, 3, 9, 1'b1, 0);
    set_geometry(2, 2, 0);
    queue_frame(2, 2, 4, 1'b1, 0);
    queue_frame(2, 2, 4, 1'b0, 0);
    set_geometry(1, 1, 2);
    queue_frame(1, 1, 3, 1'b1, 0);

    // Extremes of the registers, run without idling to keep them short.
    calm = 1'b1;
    for (int i = 0; i < swc_pkg::KSize; i++) queue_load(i, random_coef());
    set_geometry(1024, 1, 0);
    queue_frame(1024, 1, 1024, 1'b1, 0);
    set_geometry(2047, 3, 0);
    queue_frame(1024, 3, 30, 1'b1, 2);
    set_geometry(1, 4096, 0);
    queue_frame(1, 4096, 40, 1'b1, 2);
    set_geometry(1, 8191, 3);
    queue_frame(1, 8191, 20, 1'b1, 0);
    set_geometry(0, 0, 3);
    queue_frame(1, 1, 5, 1'b1, 0);
    // Fill every row slot of the columns that the random frames use.
    set_geometry(14, 5, 0);
    queue_frame(14, 5, 70, 1'b1, 0);
    calm = 1'b0;

    // Random geometries with mostly well-formed frames.
    while (queued_count < 1750) begin
      calm = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 19);
      w = (roll == 0) ? 0 : $urandom_range(1, 14);
      h = (roll == 1) ? 0 : $urandom_range(1, 9);
      set_geometry(w, h, $urandom_range(0, 3));
      w = clamp(w, 1, swc_pkg::MaxWidth);
      h = clamp(h, 1, 4096);
      if ($urandom_range(0, 2) == 0)
        for (int i = 0; i < swc_pkg::KSize; i++) queue_load(i, random_coef());
      repeat ($urandom_range(1, 3)) begin
        roll = $urandom_range(0, 99);
        if (roll < 75) queue_frame(w, h, w * h, 1'b1, 4);
        else if (roll < 88) queue_frame(w, h, w * h, 1'b0, 4);
        else queue_frame(w, h, $urandom_range(1, w * h), 1'b1, 10);
      end
    end

    while (pending_requests.size() > 0 || in_valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("sliding_window_convolution test passed");
    end else begin
      $display("sliding_window_convolution test failed");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("sliding_window_convolution test failed");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/swc_pkg.sv
hw/rtl/swc_ram.sv
hw/rtl/swc_mac.sv
hw/rtl/sliding_window_convolution.sv
verif/sliding_window_convolution_test.sv
